// ===== design/sprq_pkg.sv =====
// Shared types and codes for the sorted packet reorder queue.
package sprq_pkg;

	// Width of the capacity limit register.
	localparam int unsigned MAXE_BITS = 7;

	// Width of the command and status fields.
	localparam int unsigned CMD_BITS    = 1;
	localparam int unsigned STATUS_BITS = 3;

	// Command codes.
	localparam logic [CMD_BITS-1:0] CMD_WRITE = 1'b0;
	localparam logic [CMD_BITS-1:0] CMD_READ  = 1'b1;

	// Status codes.
	localparam logic [STATUS_BITS-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_BITS-1:0] ST_DROP_FULL = 3'd1;
	localparam logic [STATUS_BITS-1:0] ST_DROP_DUP  = 3'd2;
	localparam logic [STATUS_BITS-1:0] ST_READ_OK   = 3'd3;
	localparam logic [STATUS_BITS-1:0] ST_READ_EMPTY = 3'd4;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic clear;  // reset the search chains before a scan
		logic scan;   // advance the search chains by one cell
		logic ins;    // commit an insertion
		logic rd;     // commit a removal of the earliest entry
	} cell_ctrl_t;

endpackage

// ===== design/sorted_packet_reorder_queue_top.sv =====
// Top level of the sorted packet reorder queue: sequencer, cell chain and result register.
// A read, or a write dropped as full, goes straight to its commit. A write that is checked
// first ripples the search flags through the cell chain one cell per cycle, then commits.
// The next item is taken in the cycle after the commit; no new item is taken while one is
// in progress, and a held result delays the commit. Reset empties the queue, clears the
// limit and all control.
module sorted_packet_reorder_queue_top
	import sprq_pkg::*;
#(
	parameter int unsigned DEPTH       = 64,
	parameter int unsigned KEY_BITS    = 16,
	parameter int unsigned HANDLE_BITS = 16,
	localparam int unsigned CW         = $clog2(DEPTH + 1),
	localparam int unsigned IN_W       = ((KEY_BITS + HANDLE_BITS + 7) / 8) * 8,
	localparam int unsigned OUT_RAW_W  = 3 * KEY_BITS + HANDLE_BITS + CW,
	localparam int unsigned OUT_W      = ((OUT_RAW_W + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration: capacity limit.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [MAXE_BITS-1:0]   cfg_data,
	// Input stream.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_W-1:0]        s_tdata,   // key, handle, zero pad
	input  logic [CMD_BITS-1:0]    s_tuser,   // cmd
	// Output stream.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_W-1:0]       m_tdata,   // out_key, out_handle, count, earliest_key,
	                                          // latest_key, zero pad
	output logic [STATUS_BITS-1:0] m_tuser    // status
);

	localparam int unsigned CMPW = (CW > MAXE_BITS) ? CW : MAXE_BITS;
	localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	logic                   state_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          occ_q;
	logic [MAXE_BITS-1:0]   max_q;
	logic [CMD_BITS-1:0]    cmd_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic                   full_q;
	logic [KEY_BITS-1:0]    latest_q;

	logic [STATUS_BITS-1:0] status_q;
	logic [KEY_BITS-1:0]    out_key_q;
	logic [HANDLE_BITS-1:0] out_handle_q;
	logic [CW-1:0]          count_q;
	logic [KEY_BITS-1:0]    earliest_out_q;
	logic [KEY_BITS-1:0]    latest_out_q;
	logic                   m_valid_q;

	logic                   in_xfer;
	logic                   commit;
	logic                   full_now;
	logic [CMPW-1:0]        occ_ext;
	logic [CMPW-1:0]        max_ext;
	cell_ctrl_t             ctrl;

	logic [KEY_BITS-1:0]    cell_key    [DEPTH];
	logic [HANDLE_BITS-1:0] cell_handle [DEPTH];
	logic                   cell_s      [DEPTH];
	logic                   cell_d      [DEPTH];
	logic                   cell_t      [DEPTH];

	logic [STATUS_BITS-1:0] status_n;
	logic [CW-1:0]          occ_n;
	logic [KEY_BITS-1:0]    latest_n;
	logic [KEY_BITS-1:0]    earliest_n;
	logic                   do_ins;
	logic                   do_rd;

	// Configuration port always takes a write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			max_q <= cfg_data;
		end
	end

	// Capacity check at the input transfer.
	always_comb begin
		occ_ext  = CMPW'(occ_q);
		max_ext  = CMPW'(max_q);
		full_now = (occ_ext >= DEPTH_C) || ((max_ext != '0) && (occ_ext >= max_ext));
	end

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign commit   = (state_q == ST_BUSY) && (cnt_q == '0) && (!m_valid_q || m_tready);

	// Sequencer: capture the item, ripple the search chains, then commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_BUSY;
						cnt_q   <= (s_tuser == CMD_WRITE && !full_now) ? occ_q : '0;
					end
				end
				ST_BUSY: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
					end else if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Captured item.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q    <= s_tuser;
			key_q    <= s_tdata[KEY_BITS-1:0];
			handle_q <= s_tdata[KEY_BITS +: HANDLE_BITS];
			full_q   <= full_now;
		end
	end

	// Cell control and commit decisions.
	always_comb begin
		do_ins     = commit && (cmd_q == CMD_WRITE) && !full_q && !cell_d[0];
		do_rd      = commit && (cmd_q == CMD_READ) && (occ_q != '0);
		ctrl.clear = in_xfer;
		ctrl.scan  = (state_q == ST_BUSY) && (cnt_q != '0);
		ctrl.ins   = do_ins;
		ctrl.rd    = do_rd;

		status_n   = ST_INSERTED;
		occ_n      = occ_q;
		latest_n   = latest_q;
		earliest_n = cell_key[0];
		if (cmd_q == CMD_WRITE) begin
			if (full_q) begin
				status_n = ST_DROP_FULL;
			end else if (cell_d[0]) begin
				status_n = ST_DROP_DUP;
			end else begin
				status_n = ST_INSERTED;
				occ_n    = occ_q + 1'b1;
				if ((occ_q == '0) || cell_t[0]) begin
					latest_n = key_q;
				end
				if (!cell_s[0]) begin
					earliest_n = key_q;
				end
			end
		end else if (occ_q == '0) begin
			status_n = ST_READ_EMPTY;
		end else begin
			status_n   = ST_READ_OK;
			occ_n      = occ_q - 1'b1;
			earliest_n = cell_key[1];
		end
	end

	// Occupancy and latest key tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (commit) begin
			occ_q <= occ_n;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			latest_q <= latest_n;
		end
	end

	// Result register; the input side is free again while it waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (commit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q       <= status_n;
			out_key_q      <= do_rd ? cell_key[0] : '0;
			out_handle_q   <= do_rd ? cell_handle[0] : '0;
			count_q        <= occ_n;
			earliest_out_q <= (occ_n != '0) ? earliest_n : '0;
			latest_out_q   <= (occ_n != '0) ? latest_n : '0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = OUT_W'({latest_out_q, earliest_out_q, count_q, out_handle_q, out_key_q});

	// Chain of cells, index 0 holds the earliest entry.
	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
		logic [KEY_BITS-1:0]    below_key;
		logic [HANDLE_BITS-1:0] below_handle;
		logic                   below_s;
		logic [KEY_BITS-1:0]    above_key;
		logic [HANDLE_BITS-1:0] above_handle;
		logic                   above_s;
		logic                   above_d;
		logic                   above_t;

		if (gi == 0) begin : g_first
			assign below_key    = '0;
			assign below_handle = '0;
			assign below_s      = 1'b1;
		end else begin : g_mid_lo
			assign below_key    = cell_key[gi-1];
			assign below_handle = cell_handle[gi-1];
			assign below_s      = cell_s[gi-1];
		end

		if (gi == DEPTH - 1) begin : g_last
			assign above_key    = '0;
			assign above_handle = '0;
			assign above_s      = 1'b0;
			assign above_d      = 1'b0;
			assign above_t      = 1'b0;
		end else begin : g_mid_hi
			assign above_key    = cell_key[gi+1];
			assign above_handle = cell_handle[gi+1];
			assign above_s      = cell_s[gi+1];
			assign above_d      = cell_d[gi+1];
			assign above_t      = cell_t[gi+1];
		end

		sprq_cell #(
			.CELL_IDX    (gi),
			.CW          (CW),
			.KEY_BITS    (KEY_BITS),
			.HANDLE_BITS (HANDLE_BITS)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.new_key      (key_q),
			.new_handle   (handle_q),
			.occ          (occ_q),
			.below_key    (below_key),
			.below_handle (below_handle),
			.below_s      (below_s),
			.above_key    (above_key),
			.above_handle (above_handle),
			.above_s      (above_s),
			.above_d      (above_d),
			.above_t      (above_t),
			.key          (cell_key[gi]),
			.handle       (cell_handle[gi]),
			.s            (cell_s[gi]),
			.d            (cell_d[gi]),
			.t            (cell_t[gi])
		);
	end

endmodule

// ===== design/sprq_cell.sv =====
// One storage cell of the sorted chain: an entry plus its slice of the search chains.
module sprq_cell
	import sprq_pkg::*;
#(
	parameter int unsigned CELL_IDX    = 0,
	parameter int unsigned CW          = 7,
	parameter int unsigned KEY_BITS    = 16,
	parameter int unsigned HANDLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cell_ctrl_t             ctrl,
	input  logic [KEY_BITS-1:0]    new_key,
	input  logic [HANDLE_BITS-1:0] new_handle,
	input  logic [CW-1:0]          occ,
	input  logic [KEY_BITS-1:0]    below_key,
	input  logic [HANDLE_BITS-1:0] below_handle,
	input  logic                   below_s,
	input  logic [KEY_BITS-1:0]    above_key,
	input  logic [HANDLE_BITS-1:0] above_handle,
	input  logic                   above_s,
	input  logic                   above_d,
	input  logic                   above_t,
	output logic [KEY_BITS-1:0]    key,
	output logic [HANDLE_BITS-1:0] handle,
	output logic                   s,
	output logic                   d,
	output logic                   t
);

	localparam logic [CW-1:0] IDX  = CW'(CELL_IDX);
	localparam logic [CW-1:0] IDX1 = CW'(CELL_IDX + 1);

	logic [KEY_BITS-1:0]    key_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic                   s_q;
	logic                   d_q;
	logic                   t_q;
	logic [KEY_BITS-1:0]    diff;
	logic                   occupied;
	logic                   not_before;
	logic                   key_eq;
	logic                   is_top;

	// Local compare of the incoming key against this cell's entry.
	always_comb begin
		occupied   = IDX < occ;
		is_top     = IDX1 == occ;
		diff       = new_key - key_q;
		not_before = occupied && !diff[KEY_BITS-1];
		key_eq     = key_q == new_key;
	end

	// Search chains: the suffix flag, the duplicate flag and the top-hit flag
	// ripple one cell per cycle from the latest entry toward the earliest.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q <= 1'b0;
			d_q <= 1'b0;
			t_q <= 1'b0;
		end else if (ctrl.clear) begin
			s_q <= 1'b0;
			d_q <= 1'b0;
			t_q <= 1'b0;
		end else if (ctrl.scan) begin
			s_q <= not_before | above_s;
			d_q <= (not_before & ~above_s & key_eq) | above_d;
			t_q <= (not_before & is_top) | above_t;
		end
	end

	// Entry storage: take the new entry, shift up from below, or shift down from above.
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (!s_q) begin
				if (below_s) begin
					key_q    <= new_key;
					handle_q <= new_handle;
				end else if (IDX <= occ) begin
					key_q    <= below_key;
					handle_q <= below_handle;
				end
			end
		end else if (ctrl.rd) begin
			key_q    <= above_key;
			handle_q <= above_handle;
		end
	end

	assign key    = key_q;
	assign handle = handle_q;
	assign s      = s_q;
	assign d      = d_q;
	assign t      = t_q;

endmodule
